// ===== rtl/sensor_frame_scan_max_tracker_unit_macros.svh =====
// Assertion macros for the scan max tracker.
`ifndef SENSOR_FRAME_SCAN_MAX_TRACKER_UNIT_MACROS_SVH
`define SENSOR_FRAME_SCAN_MAX_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check on clock, disabled in reset.
`define SFSMT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sfsmt assertion failed");

// Check with an explicit clock and reset.
`define SFSMT_ASSERT_CR(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sfsmt assertion failed");

`else

`define SFSMT_ASSERT(label, prop)
`define SFSMT_ASSERT_CR(label, clk, rst, prop)

`endif

`endif

// ===== rtl/sfsmt_pkg.sv =====
`default_nettype none

package sfsmt_pkg;

   localparam int unsigned ID_STRIDE    = 10;
   localparam int unsigned GROUP_BOARDS = 7;
   localparam int unsigned GROUP_WIDTH  = 56;

   // fixed-point reciprocal of ID_STRIDE: floor(x/10) = (x * 0xCCCD) >> 19
   localparam logic [15:0] DIV10_MULT  = 16'hCCCD;
   localparam int unsigned DIV10_SHIFT = 19;

   // result status codes
   localparam logic [2:0] STAT_STORED    = 3'd0;
   localparam logic [2:0] STAT_SAFE      = 3'd1;
   localparam logic [2:0] STAT_IGNORED   = 3'd2;
   localparam logic [2:0] STAT_OVER_TEMP = 3'd3;
   localparam logic [2:0] STAT_GROUP     = 3'd4;

   // item modes
   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_GROUP = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_SENSOR_ID_BASE  = 3'd0;
   localparam logic [2:0] CSR_SAFE_STATE_ID   = 3'd1;
   localparam logic [2:0] CSR_SCAN_TARGET     = 3'd2;
   localparam logic [2:0] CSR_OVER_TEMP_ON    = 3'd3;
   localparam logic [2:0] CSR_OVER_TEMP_LIMIT = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [10:0] frame_id;
      logic [7:0]  payload_byte;
      logic [3:0]  group_index;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic                   scan_complete;
      logic [7:0]             max_reading;
      logic [7:0]             safe_state_value;
      logic [GROUP_WIDTH-1:0] group_readings;
   } rsp_type;

   // decoded sensor id, board and sensor zero-based
   typedef struct packed {
      logic       valid;
      logic [3:0] board;
      logic [3:0] sensor;
   } decode_type;

endpackage

`default_nettype wire

// ===== rtl/sfsmt_decode.sv =====
`default_nettype none

module sfsmt_decode
   import sfsmt_pkg::*;
#(
   parameter int BOARDS            = 7,
   parameter int SENSORS_PER_BOARD = 9
) (
   input  wire logic [10:0] frame_id,
   input  wire logic [10:0] sensor_id_base,
   output decode_type       dec
);

   logic        above_base;
   logic [10:0] diff;
   logic [26:0] prod;
   logic [7:0]  board_num;
   logic [10:0] board_x10;
   logic [10:0] rem_wide;
   logic [3:0]  sensor_num;

   always_comb begin
      above_base = frame_id >= sensor_id_base;
      diff       = frame_id - sensor_id_base;
      prod       = 27'(diff) * 27'(DIV10_MULT);
      board_num  = 8'(prod >> DIV10_SHIFT);
      board_x10  = 11'(board_num) * 11'(ID_STRIDE);
      rem_wide   = diff - board_x10;
      sensor_num = rem_wide[3:0];

      dec.valid  = above_base &&
                   (board_num >= 8'd1) && (board_num <= 8'(BOARDS)) &&
                   (sensor_num >= 4'd1) && (sensor_num <= 4'(SENSORS_PER_BOARD));
      dec.board  = 4'(board_num - 8'd1);
      dec.sensor = sensor_num - 4'd1;
   end

endmodule

`default_nettype wire

// ===== rtl/sfsmt_table.sv =====
`default_nettype none

module sfsmt_table
   import sfsmt_pkg::*;
#(
   parameter int BOARDS            = 7,
   parameter int SENSORS_PER_BOARD = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [3:0]             wr_board,
   input  wire logic [3:0]             wr_sensor,
   input  wire logic [7:0]             wr_data,
   input  wire logic [3:0]             rd_index,
   output      logic [GROUP_WIDTH-1:0] rd_group
);

   localparam int BW = (BOARDS > 1) ? $clog2(BOARDS) : 1;
   localparam int SW = (SENSORS_PER_BOARD > 1) ? $clog2(SENSORS_PER_BOARD) : 1;
   localparam int RD_BOARDS = (BOARDS < GROUP_BOARDS) ? BOARDS : GROUP_BOARDS;

   logic [7:0] readings_ff [BOARDS][SENSORS_PER_BOARD];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BOARDS; b++) begin
            for (int s = 0; s < SENSORS_PER_BOARD; s++) begin
               readings_ff[b][s] <= 8'd0;
            end
         end
      end else if (wr_en) begin
         readings_ff[wr_board[BW-1:0]][wr_sensor[SW-1:0]] <= wr_data;
      end
   end

   // one column across the boards; absent boards and bad index read zero
   always_comb begin
      rd_group = '0;
      if (rd_index < 4'(SENSORS_PER_BOARD)) begin
         for (int b = 0; b < RD_BOARDS; b++) begin
            rd_group[8*b +: 8] = readings_ff[b][rd_index[SW-1:0]];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_scan_max_tracker_unit.sv =====
// The start transfer is registered in the input register, then the result register drives rsp_strobe.
// Throughput: one item per cycle; busy is held low, start may be high every cycle.
// Each item yields exactly one result, shown for one cycle; the receiver cannot stall.
// Reset (synchronous): config to defaults, reading table, seen map, counters
// and latched bytes cleared, no item in flight.
`default_nettype none
`include "sensor_frame_scan_max_tracker_unit_macros.svh"

module sensor_frame_scan_max_tracker_unit
   import sfsmt_pkg::*;
#(
   parameter int BOARDS            = 7,
   parameter int SENSORS_PER_BOARD = 9
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output      logic        busy,
   input  wire req_type     req_data,
   // result channel
   output      logic        rsp_strobe,
   output      rsp_type     rsp_data,
   // register write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   localparam int BW = (BOARDS > 1) ? $clog2(BOARDS) : 1;
   localparam int SW = (SENSORS_PER_BOARD > 1) ? $clog2(SENSORS_PER_BOARD) : 1;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [10:0] id_base_ff;
   logic [10:0] safe_id_ff;
   logic [5:0]  target_ff;
   logic        ot_on_ff;
   logic [7:0]  ot_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff  <= 11'd512;
         safe_id_ff  <= 11'd1;
         target_ff   <= 6'd63;
         ot_on_ff    <= 1'b0;
         ot_limit_ff <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR_ID_BASE:  id_base_ff  <= csr_wdata;
            CSR_SAFE_STATE_ID:   safe_id_ff  <= csr_wdata;
            CSR_SCAN_TARGET:     target_ff   <= csr_wdata[5:0];
            CSR_OVER_TEMP_ON:    ot_on_ff    <= csr_wdata[0];
            CSR_OVER_TEMP_LIMIT: ot_limit_ff <= csr_wdata[7:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input register: every start transfer lands here
   // ---------------------------------------------------------------
   logic    req_valid_ff;
   req_type req_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // Id decode and reading table
   // ---------------------------------------------------------------
   decode_type             dec;
   logic [GROUP_WIDTH-1:0] group_rd;
   logic                   tbl_wr;

   sfsmt_decode #(
      .BOARDS            (BOARDS),
      .SENSORS_PER_BOARD (SENSORS_PER_BOARD)
   ) u_decode (
      .frame_id       (req_ff.frame_id),
      .sensor_id_base (id_base_ff),
      .dec            (dec)
   );

   sfsmt_table #(
      .BOARDS            (BOARDS),
      .SENSORS_PER_BOARD (SENSORS_PER_BOARD)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (tbl_wr),
      .wr_board  (dec.board),
      .wr_sensor (dec.sensor),
      .wr_data   (req_ff.payload_byte),
      .rd_index  (req_ff.group_index),
      .rd_group  (group_rd)
   );

   // ---------------------------------------------------------------
   // Scan state
   // ---------------------------------------------------------------
   logic       seen_ff [BOARDS][SENSORS_PER_BOARD];
   logic [5:0] count_ff, count_in;
   logic [7:0] scan_max_ff, scan_max_in;
   logic [7:0] latched_ff, latched_in;
   logic [7:0] safe_ff, safe_in;
   logic       seen_set, seen_clear;
   logic       done;
   logic [2:0] status;
   logic [7:0] max_next;
   logic [5:0] count_next;
   logic       was_seen;

   always_comb begin
      was_seen    = seen_ff[dec.board[BW-1:0]][dec.sensor[SW-1:0]];
      max_next    = (req_ff.payload_byte > scan_max_ff) ? req_ff.payload_byte : scan_max_ff;
      count_next  = was_seen ? count_ff : count_ff + 6'd1;

      count_in    = count_ff;
      scan_max_in = scan_max_ff;
      latched_in  = latched_ff;
      safe_in     = safe_ff;
      seen_set    = 1'b0;
      seen_clear  = 1'b0;
      tbl_wr      = 1'b0;
      done        = 1'b0;
      status      = STAT_IGNORED;

      if (req_valid_ff) begin
         priority if (req_ff.mode == MODE_GROUP) begin
            status = STAT_GROUP;
         end else if (req_ff.frame_id == safe_id_ff) begin
            // safe-state id wins over a sensor decode
            safe_in = req_ff.payload_byte;
            status  = STAT_SAFE;
         end else if (!dec.valid) begin
            status = STAT_IGNORED;
         end else if (ot_on_ff && (req_ff.payload_byte >= ot_limit_ff)) begin
            status = STAT_OVER_TEMP;
         end else begin
            status = STAT_STORED;
            tbl_wr = 1'b1;
            // count >= target also catches a target lowered mid-scan
            if (count_next >= target_ff) begin
               done        = 1'b1;
               latched_in  = max_next;
               count_in    = 6'd0;
               scan_max_in = 8'd0;
               seen_clear  = 1'b1;
            end else begin
               count_in    = count_next;
               scan_max_in = max_next;
               seen_set    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 6'd0;
         scan_max_ff <= 8'd0;
         latched_ff  <= 8'd0;
         safe_ff     <= 8'd0;
      end else begin
         count_ff    <= count_in;
         scan_max_ff <= scan_max_in;
         latched_ff  <= latched_in;
         safe_ff     <= safe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || seen_clear) begin
         for (int b = 0; b < BOARDS; b++) begin
            for (int s = 0; s < SENSORS_PER_BOARD; s++) begin
               seen_ff[b][s] <= 1'b0;
            end
         end
      end else if (seen_set) begin
         seen_ff[dec.board[BW-1:0]][dec.sensor[SW-1:0]] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Result register: one-cycle strobe
   // ---------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.status           = status;
      rsp_in.scan_complete    = done;
      rsp_in.max_reading      = latched_in;
      rsp_in.safe_state_value = safe_in;
      rsp_in.group_readings   = (status == STAT_GROUP) ? group_rd : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `SFSMT_ASSERT(a_rsp_follows_req, req_valid_ff |=> rsp_valid_ff)
   `SFSMT_ASSERT(a_rsp_has_req, rsp_valid_ff |-> $past(req_valid_ff))
   `SFSMT_ASSERT(a_done_is_stored, (rsp_valid_ff && rsp_ff.scan_complete) |-> (rsp_ff.status == STAT_STORED))
   `SFSMT_ASSERT(a_done_restarts, (rsp_valid_ff && rsp_ff.scan_complete) |-> (count_ff == 6'd0 && scan_max_ff == 8'd0))
   `SFSMT_ASSERT(a_group_only, (rsp_valid_ff && rsp_ff.status != STAT_GROUP) |-> (rsp_ff.group_readings == '0))

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
   import sfsmt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BOARD_COUNT   = 7;
   localparam int SENSOR_COUNT  = 9;
   localparam int SLOT_COUNT    = BOARD_COUNT * SENSOR_COUNT;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 115;
   // result passes the input and result registers after the start transfer; leave some margin
   localparam int SETTLE_CYCLES = 6;

   // Tracks the block's state, predicts one result per accepted command
   // and compares the strobed results in order.
   class scan_tracker_scoreboard;
      logic [10:0] id_base;
      logic [10:0] safe_id;
      logic [5:0]  target;
      logic        temp_check_on;
      logic [7:0]  temp_limit;

      logic [7:0]  readings [SLOT_COUNT];
      bit          seen [SLOT_COUNT];
      logic [5:0]  unique_count;
      logic [7:0]  scan_max;
      logic [7:0]  latched_max;
      logic [7:0]  safe_status;

      rsp_type     expected_results [$];
      int          mismatches;

      function new();
         id_base       = 11'd512;
         safe_id       = 11'd1;
         target        = 6'd63;
         temp_check_on = 1'b0;
         temp_limit    = 8'd255;
         readings      = '{default: 8'h00};
         seen          = '{default: 1'b0};
         unique_count  = '0;
         scan_max      = '0;
         latched_max   = '0;
         safe_status   = '0;
         mismatches    = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [10:0] value);
         case (index)
            CSR_SENSOR_ID_BASE:  id_base       = value;
            CSR_SAFE_STATE_ID:   safe_id       = value;
            CSR_SCAN_TARGET:     target        = value[5:0];
            CSR_OVER_TEMP_ON:    temp_check_on = value[0];
            CSR_OVER_TEMP_LIMIT: temp_limit    = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type item);
         rsp_type     res;
         logic [10:0] offset;
         int          board;
         int          sensor;
         int          slot;
         res = '0;
         if (item.mode == MODE_GROUP) begin
            res.status = STAT_GROUP;
            if (item.group_index < SENSOR_COUNT)
               for (int b = 0; b < BOARD_COUNT; b++)
                  res.group_readings[8*b +: 8] = readings[b*SENSOR_COUNT + item.group_index];
         end else if (item.frame_id == safe_id) begin
            safe_status = item.payload_byte;
            res.status  = STAT_SAFE;
         end else begin
            res.status = STAT_IGNORED;
            if (item.frame_id >= id_base) begin
               offset = item.frame_id - id_base;
               board  = offset / ID_STRIDE;
               sensor = offset % ID_STRIDE;
               if (board >= 1 && board <= BOARD_COUNT &&
                   sensor >= 1 && sensor <= SENSOR_COUNT) begin
                  if (temp_check_on && item.payload_byte >= temp_limit) begin
                     res.status = STAT_OVER_TEMP;
                  end else begin
                     slot = (board - 1) * SENSOR_COUNT + (sensor - 1);
                     res.status = STAT_STORED;
                     readings[slot] = item.payload_byte;
                     if (item.payload_byte > scan_max)
                        scan_max = item.payload_byte;
                     if (!seen[slot]) begin
                        seen[slot]   = 1'b1;
                        unique_count = unique_count + 6'd1;
                     end
                     if (unique_count >= target) begin
                        latched_max       = scan_max;
                        seen              = '{default: 1'b0};
                        unique_count      = '0;
                        scan_max          = '0;
                        res.scan_complete = 1'b1;
                     end
                  end
               end
            end
         end
         res.max_reading      = latched_max;
         res.safe_state_value = safe_status;
         expected_results.push_back(res);
      endfunction

      function void report(string field, logic [63:0] want, logic [63:0] got);
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status)
            report("status", want.status, got.status);
         if (got.scan_complete !== want.scan_complete)
            report("scan_complete", want.scan_complete, got.scan_complete);
         if (got.max_reading !== want.max_reading)
            report("max_reading", want.max_reading, got.max_reading);
         if (got.safe_state_value !== want.safe_state_value)
            report("safe_state_value", want.safe_state_value, got.safe_state_value);
         if (got.group_readings !== want.group_readings)
            report("group_readings", want.group_readings, got.group_readings);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [10:0] csr_wdata;

   scan_tracker_scoreboard tracker = new();

   int burst_left;   // commands still to go back to back
   int sweep_slot;   // walks the sensor slots in order for long scans

   sensor_frame_scan_max_tracker_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Everything is sampled at the rising edge, before the block's own
   // updates land: a command transfer is start high with busy low, a result
   // is any cycle with rsp_strobe high. The command is noted first so a
   // same-cycle result would still line up.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_request(req_data);
         if (rsp_strobe)
            tracker.check_response(rsp_data);
      end
   end

   // Hard stop in case a transfer or a result never shows up.
   initial begin
      #4ms;
      $display("FAIL sensor_frame_scan_max_tracker_unit");
      $finish;
   end

   // --- command helpers ---------------------------------------------------

   function automatic req_type frame(logic [10:0] id, logic [7:0] data);
      req_type item;
      item.mode         = MODE_FRAME;
      item.frame_id     = id;
      item.payload_byte = data;
      item.group_index  = 4'($urandom_range(0, 15));
      return item;
   endfunction

   function automatic req_type group_read(logic [3:0] index);
      req_type item;
      item.mode         = MODE_GROUP;
      item.frame_id     = 11'($urandom_range(0, 2047));
      item.payload_byte = 8'($urandom_range(0, 255));
      item.group_index  = index;
      return item;
   endfunction

   // id of a decodable sensor for a 0-based slot under the current base
   function automatic logic [10:0] slot_id(int slot);
      return tracker.id_base + 11'((slot / SENSOR_COUNT + 1) * ID_STRIDE)
             + 11'(slot % SENSOR_COUNT + 1);
   endfunction

   // payloads: mostly uniform, with the extremes and the fault threshold
   // edges hit on purpose
   function automatic logic [7:0] reading_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return 8'h00;
      if (r < 10) return 8'hFF;
      if (r < 14) return tracker.temp_limit;
      if (r < 18) return tracker.temp_limit - 8'd1;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed sensor frames so scans actually complete; the rest
   // is group reads, safe-state frames and ids that may or may not decode.
   function automatic req_type random_item(bit sweep);
      req_type item;
      int      r;
      int      slot;
      r    = $urandom_range(0, 99);
      item = frame(11'($urandom_range(0, 2047)), reading_value());
      if (r < 15) begin
         item = group_read(4'(r < 13 ? $urandom_range(0, 8) : $urandom_range(9, 15)));
      end else if (r < 23) begin
         item.frame_id = tracker.safe_id;
      end else if (r < 83) begin
         if (sweep) begin
            slot       = sweep_slot % SLOT_COUNT;
            sweep_slot = sweep_slot + 1;
         end else begin
            slot = $urandom_range(0, SLOT_COUNT - 1);
         end
         item.frame_id = slot_id(slot);
      end else if (r < 93) begin
         // near the base: board or sensor digit may be out of range
         item.frame_id = tracker.id_base + 11'($urandom_range(0, 89));
      end
      return item;
   endfunction

   // Gap after a transfer: mostly none or short, a few long, and now and
   // then a burst of back-to-back commands.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left = burst_left - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Holds start and the command until the transfer edge. Called right
   // after a rising edge; start is raised once and only dropped by a gap.
   task automatic issue(req_type item);
      int gap;
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop issuing and wait for every predicted result, plus a few cycles.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(logic [2:0] index, logic [10:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [10:0] base, logic [10:0] safe, logic [5:0] scan_len,
                            logic check_on, logic [7:0] limit);
      write_reg(CSR_SENSOR_ID_BASE, base);
      write_reg(CSR_SAFE_STATE_ID, safe);
      write_reg(CSR_SCAN_TARGET, 11'(scan_len));
      write_reg(CSR_OVER_TEMP_ON, 11'(check_on));
      write_reg(CSR_OVER_TEMP_LIMIT, 11'(limit));
   endtask

   // --- main sequence -----------------------------------------------------

   initial begin
      logic [10:0] base;
      logic [5:0]  scan_len;
      start      <= 1'b0;
      req_data   <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      burst_left = 0;
      sweep_slot = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset configuration: base 512, safe id 1, full scan.
      // Group reads on an empty table, including an index past the last sensor.
      issue(group_read(4'd0));
      issue(group_read(4'd8));
      issue(group_read(4'd15));
      // safe-state frame, both byte extremes
      issue(frame(11'd1, 8'hFF));
      issue(frame(11'd1, 8'h00));
      // id 522 (board 1, sensor 0, no decode), the last sensor, then id 522 again
      issue(frame(11'd522, 8'h00));
      issue(frame(11'd591, 8'hFF));
      issue(frame(11'd522, 8'h4D));
      // ids that do not decode: below base, board 0 (twice), board 8, extremes
      issue(frame(11'd511, 8'h11));
      issue(frame(11'd512, 8'h22));
      issue(frame(11'd520, 8'h33));
      issue(frame(11'd592, 8'h44));
      issue(frame(11'd2047, 8'h55));
      issue(frame(11'd0, 8'h66));
      issue(group_read(4'd0));
      issue(group_read(4'd8));
      drain();

      // Safe-state id on board 1 sensor 0, which does not decode; target lowered to 2,
      // one above the count already reached; fault check on at 200.
      configure(11'd512, 11'd522, 6'd2, 1'b1, 8'd200);
      issue(frame(11'd522, 8'd33));
      issue(frame(11'd531, 8'd200));
      issue(frame(11'd531, 8'd255));
      issue(frame(11'd531, 8'd199));
      drain();

      // Target of zero; fault limit of zero faults every reading.
      configure(11'd512, 11'd1, 6'd0, 1'b1, 8'd0);
      issue(frame(11'd543, 8'd0));
      drain();
      write_reg(CSR_OVER_TEMP_ON, 11'd0);
      issue(frame(11'd543, 8'd0));
      drain();

      // Highest base: nothing decodes. Unused register index is a no-op.
      write_reg(CSR_SENSOR_ID_BASE, 11'd2047);
      write_reg(3'd7, 11'h5A5);
      issue(frame(11'd2047, 8'd9));
      drain();
      // Base where the last sensor lands on the top id.
      write_reg(CSR_SENSOR_ID_BASE, 11'd1968);
      issue(frame(11'd2047, 8'd1));
      issue(group_read(4'd8));
      drain();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: configure(11'd0, 11'd2047, 6'd1, 1'b0, 8'd255);
            1: configure(11'd1968, 11'd0, 6'd63, 1'b1, 8'd255);
            2: configure(11'd512, 11'd1, 6'd63, 1'b0, 8'd255);
            default: begin
               base     = 11'($urandom_range(0, 1968));
               scan_len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(1, 12));
               // sometimes put the safe-state id on a live sensor id
               configure(base,
                         ($urandom_range(0, 2) == 0) ? base + 11'd21
                                                     : 11'($urandom_range(0, 2047)),
                         scan_len, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            end
         endcase
         sweep_slot = $urandom_range(0, SLOT_COUNT - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            issue(random_item(tracker.target > 6'd20));
         drain();
      end

      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
         $display("PASS sensor_frame_scan_max_tracker_unit");
      else
         $display("FAIL sensor_frame_scan_max_tracker_unit");
      $finish;
   end

endmodule
